/* rtl/bounded_indexed_list_defines.svh */
// ----------------------------------------------------------------------------
// bounded_indexed_list assertion macros
// shared property shapes for the list checker
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INDEXED_LIST_DEFINES_SVH
`define BOUNDED_INDEXED_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BLIST_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BLIST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/blist_pkg.sv */
// ----------------------------------------------------------------------------
// blist_pkg
// shared widths, codes and control types of the bounded indexed list
// ----------------------------------------------------------------------------
`default_nettype none

package blist_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 5;
  localparam int STATUS_W = 2;
  localparam int MAX_W    = 5;

  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = MAX_W'(10);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_REMOVE  = 3'd1,
    KIND_READ    = 3'd2,
    KIND_REPLACE = 3'd3,
    KIND_SEARCH  = 3'd4,
    KIND_MAX     = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             wr;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  // scan token walking down the chain
  typedef struct packed {
    logic vld;
    logic found;
  } tok_t;

endpackage

`default_nettype wire

/* rtl/blist_req_if.sv */
// ----------------------------------------------------------------------------
// blist_req_if
// request channel of the bounded indexed list
// ----------------------------------------------------------------------------
`default_nettype none

interface blist_req_if #(
  parameter int DW = blist_pkg::DATA_WIDTH_DEF
);
  import blist_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [POS_W-1:0]     position;
  logic signed [DW-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

`default_nettype wire

/* rtl/blist_rsp_if.sv */
// ----------------------------------------------------------------------------
// blist_rsp_if
// result channel of the bounded indexed list
// ----------------------------------------------------------------------------
`default_nettype none

interface blist_rsp_if #(
  parameter int DW = blist_pkg::DATA_WIDTH_DEF
);
  import blist_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic signed [DW-1:0] result_value;
  logic [CNT_W-1:0]     entry_count;

  modport source (output valid, status, found, result_value, entry_count, input ready);
  modport sink   (input valid, status, found, result_value, entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/blist_cfg_if.sv */
// ----------------------------------------------------------------------------
// blist_cfg_if
// capacity register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface blist_cfg_if;
  import blist_pkg::*;

  logic             valid;
  logic             ready;
  logic [MAX_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/blist_cell.sv */
// ----------------------------------------------------------------------------
// blist_cell
// one list slot: shifts with its neighbors and folds the scan token
// ----------------------------------------------------------------------------
`default_nettype none

module blist_cell #(
  parameter int IDX = 0,
  parameter int DW  = blist_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire blist_pkg::cmd_t      cmd,
  input  wire logic signed [DW-1:0] value,
  input  wire logic signed [DW-1:0] key,
  input  wire logic signed [DW-1:0] left,
  input  wire logic signed [DW-1:0] right,
  output logic signed [DW-1:0]      ent,
  input  wire blist_pkg::tok_t      tok_i,
  input  wire logic signed [DW-1:0] acc_i,
  output blist_pkg::tok_t           tok_o,
  output logic signed [DW-1:0]      acc_o
);
  import blist_pkg::*;

  localparam int unsigned Ix = IDX;

  logic signed [DW-1:0] ent_r, ent_nxt;
  tok_t                 tok_r, tok_nxt;
  logic signed [DW-1:0] acc_r, acc_nxt;
  logic                 active;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins) begin
      if (Ix == 32'(cmd.pos)) begin
        ent_nxt = value;
      end else if (Ix > 32'(cmd.pos) && Ix <= 32'(cmd.cnt)) begin
        ent_nxt = left;
      end
    end else if (cmd.rem) begin
      if (Ix >= 32'(cmd.pos) && Ix + 1 < 32'(cmd.cnt)) begin
        ent_nxt = right;
      end
    end else if (cmd.wr && Ix == 32'(cmd.pos)) begin
      ent_nxt = value;
    end
  end

  assign active = Ix < 32'(cmd.cnt);

  always_comb begin
    tok_nxt.vld   = tok_i.vld;
    tok_nxt.found = tok_i.found | (active && ent_r == key);
    acc_nxt       = (active && ent_r > acc_i) ? ent_r : acc_i;
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign ent   = ent_r;
  assign tok_o = tok_r;
  assign acc_o = acc_r;

endmodule

`default_nettype wire

/* rtl/bounded_indexed_list.sv */
// ----------------------------------------------------------------------------
// bounded_indexed_list
// ordered list of signed entries kept in a row of shifting cells
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid / ready      | kind, position, value
//  out_ch  | out | valid / ready      | status, found, result_value, entry_count
//  cfg_ch  | in  | valid / ready (=1) | data -> max_entries
//
//  insert, remove, read, replace, unused kinds: result registered the cycle after
//  the request is taken; insert/remove shift cells from position on, replace
//  writes its cell, in that same cycle; search and maximum: result registered
//  as the scan token leaves the last cell, stepping through one cell per cycle
//  one request in flight; in_ch.ready waits while out_ch holds an untaken result
//  reset: count 0, max_entries 10, entries left as they are (no clearing pass)
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list #(
  parameter int DEPTH      = blist_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = blist_pkg::DATA_WIDTH_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  blist_req_if.sink  in_ch,
  blist_rsp_if.source out_ch,
  blist_cfg_if.sink  cfg_ch
);
  import blist_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                       state_r;
  logic                         out_vld_r;
  logic [STATUS_W-1:0]          status_r;
  logic                         found_r;
  logic signed [DATA_WIDTH-1:0] res_r;
  logic [CNT_W-1:0]             cnt_out_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [MAX_W-1:0]             max_entries_r;
  logic                         start_r;
  logic                         is_max_r;
  logic signed [DATA_WIDTH-1:0] key_r;

  logic                         req_acc;
  logic                         scan_go;
  status_t                      st;
  logic signed [DATA_WIDTH-1:0] res;
  logic signed [DATA_WIDTH-1:0] rd_data;
  logic [CNT_W-1:0]             cap;
  cmd_t                         cmd;

  logic signed [DATA_WIDTH-1:0] ent [DEPTH];
  tok_t                         tok [DEPTH+1];
  logic signed [DATA_WIDTH-1:0] acc [DEPTH+1];

  assign in_ch.ready  = (state_r == ST_IDLE) && (!out_vld_r || out_ch.ready);
  assign req_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cap = (32'(max_entries_r) < DEPTH) ? max_entries_r : CNT_W'(DEPTH);

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (32'(in_ch.position) == 32'(i)) begin
        rd_data = ent[i];
      end
    end
  end

  always_comb begin
    st        = STATUS_OK;
    res       = '0;
    count_nxt = count_r;
    scan_go   = 1'b0;
    cmd       = '0;
    cmd.pos   = in_ch.position;
    cmd.cnt   = count_r;
    case (kind_t'(in_ch.kind))
      KIND_INSERT: begin
        if (in_ch.position > count_r) begin
          st = STATUS_BAD_POS;
        end else if (count_r >= cap) begin
          st = STATUS_FULL;
        end else begin
          cmd.ins   = req_acc;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (in_ch.position >= count_r) begin
          st = STATUS_BAD_POS;
        end else begin
          cmd.rem   = req_acc;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_READ: begin
        if (in_ch.position >= count_r) begin
          st = STATUS_BAD_POS;
        end else begin
          res = rd_data;
        end
      end
      KIND_REPLACE: begin
        if (in_ch.position >= count_r) begin
          st = STATUS_BAD_POS;
        end else begin
          cmd.wr = req_acc;
        end
      end
      KIND_SEARCH, KIND_MAX: begin
        scan_go = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // scan token enters the chain the cycle after the request
  assign tok[0].vld   = start_r;
  assign tok[0].found = 1'b0;
  assign acc[0]       = key_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = in_ch.value;
    end else begin : g_mid_l
      assign left_w = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = ent[g];
    end else begin : g_mid_r
      assign right_w = ent[g+1];
    end

    blist_cell #(
      .IDX (g),
      .DW  (DATA_WIDTH)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .value (in_ch.value),
      .key   (key_r),
      .left  (left_w),
      .right (right_w),
      .ent   (ent[g]),
      .tok_i (tok[g]),
      .acc_i (acc[g]),
      .tok_o (tok[g+1]),
      .acc_o (acc[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_vld_r     <= 1'b0;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      start_r       <= 1'b0;
    end else begin
      start_r <= req_acc && scan_go;
      if (cfg_ch.valid) begin
        max_entries_r <= cfg_ch.data;
      end
      if (req_acc) begin
        count_r <= count_nxt;
      end
      case (state_r)
        ST_IDLE: begin
          if (req_acc && scan_go) begin
            state_r  <= ST_SCAN;
            key_r    <= in_ch.value;
            is_max_r <= (kind_t'(in_ch.kind) == KIND_MAX);
          end
        end
        ST_SCAN: begin
          if (tok[DEPTH].vld) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (req_acc && !scan_go) begin
        out_vld_r <= 1'b1;
        status_r  <= st;
        found_r   <= 1'b0;
        res_r     <= res;
        cnt_out_r <= count_nxt;
      end else if (tok[DEPTH].vld) begin
        out_vld_r <= 1'b1;
        status_r  <= STATUS_OK;
        found_r   <= is_max_r ? 1'b0 : tok[DEPTH].found;
        res_r     <= is_max_r ? acc[DEPTH] : '0;
        cnt_out_r <= count_r;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = status_r;
  assign out_ch.found        = found_r;
  assign out_ch.result_value = res_r;
  assign out_ch.entry_count  = cnt_out_r;

endmodule

`default_nettype wire

/* rtl/blist_chk.sv */
// ----------------------------------------------------------------------------
// blist_chk
// port-level checks of the bounded indexed list, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "bounded_indexed_list_defines.svh"

module blist_chk #(
  parameter int DW = blist_pkg::DATA_WIDTH_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [blist_pkg::STATUS_W-1:0] out_status,
  input wire logic                          out_found,
  input wire logic [DW-1:0]                 out_result_value,
  input wire logic [blist_pkg::CNT_W-1:0]   out_entry_count
);
  import blist_pkg::*;

  logic             in_acc, out_acc;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] prev_cnt_r;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pend_nxt = in_acc | (pend_r & ~out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      prev_cnt_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_acc) begin
        prev_cnt_r <= out_entry_count;
      end
    end
  end

  `BLIST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_result_value) && $stable(out_entry_count),
    "result changed while stalled")

  `BLIST_ASSERT_NOW(a_one_in_flight, in_acc, !pend_r || out_acc,
    "request taken while another is outstanding")

  `BLIST_ASSERT_NOW(a_reject_zero, out_valid && out_status != STATUS_OK,
    !out_found && out_result_value == '0, "rejected request returned data")

  `BLIST_ASSERT_NOW(a_count_step, out_acc,
    out_entry_count == prev_cnt_r || out_entry_count == prev_cnt_r + 1'b1 ||
    prev_cnt_r == out_entry_count + 1'b1, "entry count jumped by more than one")

endmodule

bind bounded_indexed_list blist_chk #(
  .DW (DATA_WIDTH)
) u_blist_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_found        (out_ch.found),
  .out_result_value (out_ch.result_value),
  .out_entry_count  (out_ch.entry_count)
);

`default_nettype wire

/* verif/bounded_indexed_list_tb.sv */
// ----------------------------------------------------------------------------
// bounded_indexed_list_tb
// Drives list requests and capacity writes into the bounded indexed list and
// checks every result against a shadow list in the bench or a scripted reply.
// A short scripted sequence covers the empty list, the value extremes, bad
// positions, a full list and the unused kinds. Random phases follow under
// several capacities, with random stalls on both channels in all but the last three.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_indexed_list_tb;
  import blist_pkg::*;

  localparam int DW              = DATA_WIDTH_DEF;
  localparam int DEPTH           = DEPTH_DEF;
  localparam int MAX_REPORTS     = 10;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_SCRIPT_ROWS = 28;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    status_t                status;
    logic                   found;
    logic signed [DW-1:0]   result_value;
    logic [CNT_W-1:0]       entry_count;
  } list_reply_t;

  typedef enum logic {ROW_REQUEST, ROW_CAPACITY} row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     pos;
    logic signed [DW-1:0] value;
    logic                 typed;
    status_t              status;
    logic                 found;
    logic signed [DW-1:0] result;
    logic [CNT_W-1:0]     count;
  } script_row_t;

  // capacity rows carry the register value in the value field
  localparam script_row_t SCRIPT [NUM_SCRIPT_ROWS] = '{
    '{ROW_REQUEST,  KIND_READ,      5'd0,  32'sd0,        1'b1, STATUS_BAD_POS, 1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_REMOVE,    5'd0,  32'sd0,        1'b1, STATUS_BAD_POS, 1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_SEARCH,    5'd0,  32'sd0,        1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_MAX,       5'd0,  VAL_MIN,       1'b1, STATUS_OK,      1'b0, VAL_MIN, 5'd0},
    '{ROW_REQUEST,  KIND_INSERT,    5'd1,  32'sd1,        1'b1, STATUS_BAD_POS, 1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_INSERT,    5'd0,  VAL_MAX,       1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd1},
    '{ROW_REQUEST,  KIND_REMOVE,    5'd0,  32'sd0,        1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_INSERT,    5'd0,  VAL_MAX,       1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd1},
    '{ROW_REQUEST,  KIND_INSERT,    5'd0,  VAL_MIN,       1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd2},
    '{ROW_REQUEST,  KIND_INSERT,    5'd2,  32'sd0,        1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd3},
    '{ROW_REQUEST,  KIND_INSERT,    5'd1,  -32'sd1,       1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_READ,      5'd3,  32'sd0,        1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_READ,      5'd4,  32'sd0,        1'b1, STATUS_BAD_POS, 1'b0, 32'sd0,  5'd4},
    '{ROW_REQUEST,  KIND_REPLACE,   5'd16, VAL_MIN,       1'b1, STATUS_BAD_POS, 1'b0, 32'sd0,  5'd4},
    '{ROW_REQUEST,  KIND_SEARCH,    5'd0,  VAL_MAX,       1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_SEARCH,    5'd0,  32'sd5,        1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_MAX,       5'd0,  VAL_MIN,       1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_REPLACE,   5'd0,  32'sh5555AAAA, 1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_REMOVE,    5'd1,  32'sd0,        1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_UNUSED_LO, 5'd0,  32'sd0,        1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd3},
    '{ROW_REQUEST,  KIND_UNUSED_HI, 5'd31, -32'sd1,       1'b1, STATUS_OK,      1'b0, 32'sd0,  5'd3},
    '{ROW_CAPACITY, KIND_INSERT,    5'd0,  32'sd2,        1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_INSERT,    5'd0,  32'sd7,        1'b1, STATUS_FULL,    1'b0, 32'sd0,  5'd3},
    '{ROW_REQUEST,  KIND_INSERT,    5'd4,  32'sd7,        1'b1, STATUS_BAD_POS, 1'b0, 32'sd0,  5'd3},
    '{ROW_CAPACITY, KIND_INSERT,    5'd0,  32'sd0,        1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_INSERT,    5'd3,  32'sd7,        1'b1, STATUS_FULL,    1'b0, 32'sd0,  5'd3},
    '{ROW_CAPACITY, KIND_INSERT,    5'd0,  32'sd16,       1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0},
    '{ROW_REQUEST,  KIND_MAX,       5'd0,  VAL_MIN,       1'b0, STATUS_OK,      1'b0, 32'sd0,  5'd0}
  };

  localparam logic [MAX_W-1:0] PHASE_CAPACITY [NUM_PHASES] =
    '{5'd16, 5'd1, 5'd7, 5'd31, 5'd0, 5'd3, 5'd16, 5'd12, 5'd10};

  logic clk;
  logic rst_n;

  blist_req_if #(.DW(DW)) req_if ();
  blist_rsp_if #(.DW(DW)) rsp_if ();
  blist_cfg_if            cfg_if ();

  bounded_indexed_list #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if),
    .cfg_ch (cfg_if)
  );

  logic signed [DW-1:0] held_entries [DEPTH];
  logic [CNT_W-1:0]     held_count;
  logic [MAX_W-1:0]     held_max_entries;
  list_reply_t          list_replies [$];

  int sender_idle_pct;
  int receiver_idle_pct;
  int failures;
  int results_checked;
  int capacity_writes;
  int full_seen;
  int bad_pos_seen;
  int kind_seen [8];
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic list_reply_t apply_list_request(input logic [KIND_W-1:0] kind,
      input logic [POS_W-1:0] pos, input logic signed [DW-1:0] val);
    list_reply_t          r;
    int                   cap;
    logic signed [DW-1:0] best;
    r = '0;
    r.status = STATUS_OK;
    cap = (held_max_entries < DEPTH) ? int'(held_max_entries) : DEPTH;
    case (kind)
      KIND_INSERT: begin
        if (pos > held_count) begin
          r.status = STATUS_BAD_POS;
        end else if (held_count >= cap) begin
          r.status = STATUS_FULL;
        end else begin
          for (int i = held_count; i > pos; i--) held_entries[i] = held_entries[i-1];
          held_entries[pos] = val;
          held_count++;
        end
      end
      KIND_REMOVE: begin
        if (pos >= held_count) begin
          r.status = STATUS_BAD_POS;
        end else begin
          for (int i = pos; i + 1 < held_count; i++) held_entries[i] = held_entries[i+1];
          held_count--;
        end
      end
      KIND_READ: begin
        if (pos >= held_count) r.status = STATUS_BAD_POS;
        else r.result_value = held_entries[pos];
      end
      KIND_REPLACE: begin
        if (pos >= held_count) r.status = STATUS_BAD_POS;
        else held_entries[pos] = val;
      end
      KIND_SEARCH: begin
        for (int i = 0; i < held_count; i++)
          if (held_entries[i] == val) r.found = 1'b1;
      end
      KIND_MAX: begin
        best = val;
        for (int i = 0; i < held_count; i++)
          if (held_entries[i] > best) best = held_entries[i];
        r.result_value = best;
      end
      default: ;
    endcase
    r.entry_count = held_count;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -1;
      3, 4, 5: return $signed($urandom_range(15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("error: %s", msg);
  endtask

  // mostly well-formed positions, steered toward a fill level
  task automatic pick_random_request(input int fill_goal, output logic [KIND_W-1:0] kind,
      output logic [POS_W-1:0] pos, output logic signed [DW-1:0] val);
    int w;
    int p;
    int insert_top;
    w = $urandom_range(99);
    insert_top = (held_count < fill_goal) ? 42 : 22;
    if (w < 2) kind = $urandom_range(1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
    else if (w < insert_top) kind = KIND_INSERT;
    else if (w < 54) kind = KIND_REMOVE;
    else if (w < 66) kind = KIND_READ;
    else if (w < 78) kind = KIND_REPLACE;
    else if (w < 90) kind = KIND_SEARCH;
    else kind = KIND_MAX;
    p = $urandom_range(99);
    if (p < 12) pos = POS_W'($urandom_range(16));
    else if (p < 15) pos = POS_W'($urandom_range(31, 17));
    else if (kind == KIND_INSERT) pos = POS_W'($urandom_range(held_count));
    else if (held_count == 0) pos = '0;
    else pos = POS_W'($urandom_range(held_count - 1));
    val = pick_value();
    if (kind == KIND_SEARCH && held_count != 0 && $urandom_range(1) == 1)
      val = held_entries[$urandom_range(held_count - 1)];
  endtask

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
      input logic signed [DW-1:0] val, input logic typed, input list_reply_t typed_reply);
    list_reply_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.kind     <= kind;
    req_if.position <= pos;
    req_if.value    <= val;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predicted = apply_list_request(kind, pos, val);
    kind_seen[kind]++;
    if (predicted.status == STATUS_FULL) full_seen++;
    else if (predicted.status == STATUS_BAD_POS) bad_pos_seen++;
    list_replies.push_back(typed ? typed_reply : predicted);
  endtask

  // capacity changes only once every result is back
  task automatic set_capacity(input logic [MAX_W-1:0] data);
    req_if.valid <= 1'b0;
    while (list_replies.size() != 0) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    held_max_entries = data;
    capacity_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_reply();
    list_reply_t want;
    results_checked++;
    if (list_replies.size() == 0) begin
      note_failure($sformatf("result %0d arrived with no request outstanding", results_checked));
    end else begin
      want = list_replies.pop_front();
      if (rsp_if.status !== want.status || rsp_if.found !== want.found ||
          rsp_if.result_value !== want.result_value ||
          rsp_if.entry_count !== want.entry_count)
        note_failure($sformatf({"result %0d: expected status %0d found %0b value %0d count %0d,",
          " got status %0d found %0b value %0d count %0d"}, results_checked,
          want.status, want.found, want.result_value, want.entry_count,
          rsp_if.status, rsp_if.found, rsp_if.result_value, rsp_if.entry_count));
    end
  endtask

  initial begin
    forever begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) check_reply();
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [KIND_W-1:0]    kind;
    logic [POS_W-1:0]     pos;
    logic signed [DW-1:0] val;
    int                   cap;
    int                   fill_goal;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.kind     <= '0;
    req_if.position <= '0;
    req_if.value    <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    sender_idle_pct   = 14;
    receiver_idle_pct = 67;
    failures          = 0;
    results_checked   = 0;
    capacity_writes   = 0;
    full_seen         = 0;
    bad_pos_seen      = 0;
    idle_cycles       = 0;
    foreach (kind_seen[k]) kind_seen[k] = 0;
    foreach (held_entries[i]) held_entries[i] = '0;
    held_count       = '0;
    held_max_entries = MAX_ENTRIES_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].op == ROW_CAPACITY)
        set_capacity(SCRIPT[r].value[MAX_W-1:0]);
      else
        send_request(SCRIPT[r].kind, SCRIPT[r].pos, SCRIPT[r].value, SCRIPT[r].typed,
          list_reply_t'{SCRIPT[r].status, SCRIPT[r].found, SCRIPT[r].result,
          SCRIPT[r].count});
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3) begin
        sender_idle_pct   = 67;
        receiver_idle_pct = 14;
      end else if (ph == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      set_capacity(PHASE_CAPACITY[ph]);
      cap = (PHASE_CAPACITY[ph] < DEPTH) ? int'(PHASE_CAPACITY[ph]) : DEPTH;
      fill_goal = (ph % 2 == 0) ? cap : cap / 2;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick_random_request(fill_goal, kind, pos, val);
        send_request(kind, pos, val, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (list_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (list_replies.size() != 0)
      note_failure($sformatf("%0d results never arrived", list_replies.size()));

    $display("covered requests: insert %0d, remove %0d, read %0d, replace %0d, search %0d, max %0d, unused %0d",
      kind_seen[KIND_INSERT], kind_seen[KIND_REMOVE], kind_seen[KIND_READ],
      kind_seen[KIND_REPLACE], kind_seen[KIND_SEARCH], kind_seen[KIND_MAX],
      kind_seen[KIND_UNUSED_LO] + kind_seen[KIND_UNUSED_HI]);
    $display("%0d capacity writes, %0d full refusals, %0d bad positions, %0d results, %0d errors",
      capacity_writes, full_seen, bad_pos_seen, results_checked, failures);
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/blist_pkg.sv
rtl/blist_req_if.sv
rtl/blist_rsp_if.sv
rtl/blist_cfg_if.sv
rtl/blist_cell.sv
rtl/bounded_indexed_list.sv
rtl/blist_chk.sv
verif/bounded_indexed_list_tb.sv
